[src/mqttpp_pkg.sv]
// Shared types, codes and id decode for the MQTT 5 property list parser.
package mqttpp_pkg;

  localparam int unsigned PosW = 29;
  localparam int unsigned LenW = 28;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_VINT_LONG = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;

  localparam logic [2:0] K_BYTE   = 3'd0;
  localparam logic [2:0] K_TWO    = 3'd1;
  localparam logic [2:0] K_FOUR   = 3'd2;
  localparam logic [2:0] K_STRING = 3'd3;
  localparam logic [2:0] K_BINARY = 3'd4;
  localparam logic [2:0] K_PAIR   = 3'd5;
  localparam logic [2:0] K_VARINT = 3'd6;
  localparam logic [2:0] K_NONE   = 3'd7;

  typedef struct packed {
    logic [2:0]      status;
    logic [7:0]      prop_id;
    logic [2:0]      value_kind;
    logic [31:0]     num_value;
    logic [15:0]     first_len;
    logic [15:0]     second_len;
    logic [PosW-1:0] content_offset;
    logic [PosW-1:0] bytes_used;
    logic            section_end;
  } res_t;

  function automatic logic [2:0] kind_of(input logic [7:0] id);
    logic [2:0] k;
    case (id)
      8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: k = K_BYTE;
      8'h13, 8'h21, 8'h22, 8'h23:                             k = K_TWO;
      8'h02, 8'h11, 8'h18, 8'h27:                             k = K_FOUR;
      8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F:        k = K_STRING;
      8'h09, 8'h16:                                           k = K_BINARY;
      8'h26:                                                  k = K_PAIR;
      8'h0B:                                                  k = K_VARINT;
      default:                                                k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

[src/mqttpp_core.sv]
// Per-byte parse state and descriptor generation for the property list parser.
module mqttpp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        data_i,
  input  logic              start_i,
  output logic              res_valid_o,
  output mqttpp_pkg::res_t  res_o
);
  import mqttpp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SECLEN, PH_ID, PH_FIXED, PH_L1HI, PH_L1LO,
    PH_SKIP1, PH_L2HI, PH_L2LO, PH_SKIP2, PH_VINT
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [LenW-1:0] vacc_q, vacc_d;
  logic [2:0]      vcnt_q, vcnt_d;
  logic [7:0]      id_q, id_d;
  logic [2:0]      kind_q, kind_d;
  logic [15:0]     fc_q, fc_d;
  logic [31:0]     val_q, val_d;
  logic [15:0]     l1_q, l1_d;
  logic [15:0]     l2_q, l2_d;
  logic [PosW-1:0] bp_q, bp_d;
  logic [PosW-1:0] cpos_q, cpos_d;

  function automatic logic [LenW-1:0] vgroup(input logic [1:0] cnt, input logic [6:0] b);
    logic [LenW-1:0] g;
    case (cnt)
      2'd0:    g = {21'd0, b};
      2'd1:    g = {14'd0, b, 7'd0};
      2'd2:    g = {7'd0, b, 14'd0};
      2'd3:    g = {b, 21'd0};
      default: g = '0;
    endcase
    return g;
  endfunction

  always_comb begin
    logic       done;
    logic       numeric;
    logic [2:0] kind_n;
    phase_d = phase_q; rem_d = rem_q; vacc_d = vacc_q; vcnt_d = vcnt_q;
    id_d = id_q; kind_d = kind_q; fc_d = fc_q; val_d = val_q;
    l1_d = l1_q; l2_d = l2_q; bp_d = bp_q; cpos_d = cpos_q;
    res_valid_o = 1'b0;
    res_o = '0;
    done = 1'b0;
    numeric = 1'b0;
    kind_n = kind_of(data_i);
    if (beat_i && (start_i || phase_q != PH_IDLE)) begin
      if (start_i) begin
        phase_d = PH_SECLEN; rem_d = '0; vacc_d = '0; vcnt_d = '0;
        id_d = '0; kind_d = '0; fc_d = '0; val_d = '0;
        l1_d = '0; l2_d = '0; bp_d = '0; cpos_d = '0;
      end
      bp_d = bp_d + PosW'(1);
      res_o.bytes_used = bp_d;
      if (phase_d == PH_SECLEN) begin
        if (vcnt_d[2]) begin
          res_valid_o = 1'b1;
          res_o.status = ST_VINT_LONG;
          res_o.section_end = 1'b1;
        end else begin
          vacc_d = vacc_d + vgroup(vcnt_d[1:0], data_i[6:0]);
          vcnt_d = vcnt_d + 3'd1;
          if (!data_i[7]) begin
            rem_d = vacc_d;
            if (vacc_d == '0) begin
              res_valid_o = 1'b1;
              res_o.status = ST_EMPTY;
              res_o.section_end = 1'b1;
            end else begin
              phase_d = PH_ID;
            end
          end
        end
      end else begin
        rem_d = rem_d - LenW'(1);
        case (phase_d)
          PH_ID: begin
            id_d = data_i;
            if (kind_n == K_NONE) begin
              kind_d = K_BYTE;
              res_valid_o = 1'b1;
              res_o.status = ST_UNKNOWN;
              res_o.prop_id = data_i;
              res_o.section_end = 1'b1;
            end else begin
              kind_d = kind_n;
              val_d = '0; l1_d = '0; l2_d = '0; cpos_d = '0;
              if (kind_n == K_BYTE || kind_n == K_TWO || kind_n == K_FOUR) begin
                fc_d = (kind_n == K_BYTE) ? 16'd1 : (kind_n == K_TWO) ? 16'd2 : 16'd4;
                phase_d = PH_FIXED;
              end else if (kind_n == K_VARINT) begin
                vacc_d = '0; vcnt_d = '0;
                phase_d = PH_VINT;
              end else begin
                phase_d = PH_L1HI;
              end
            end
          end
          PH_FIXED: begin
            val_d = {val_d[23:0], data_i};
            fc_d = fc_d - 16'd1;
            done = (fc_d == '0);
          end
          PH_L1HI: begin
            l1_d = {data_i, 8'd0};
            phase_d = PH_L1LO;
          end
          PH_L1LO: begin
            l1_d = {l1_d[15:8], data_i};
            cpos_d = bp_d;
            if (l1_d != '0) begin
              fc_d = l1_d;
              phase_d = PH_SKIP1;
            end else if (kind_d == K_PAIR) begin
              phase_d = PH_L2HI;
            end else begin
              done = 1'b1;
            end
          end
          PH_SKIP1: begin
            fc_d = fc_d - 16'd1;
            if (fc_d == '0) begin
              if (kind_d == K_PAIR) phase_d = PH_L2HI;
              else done = 1'b1;
            end
          end
          PH_L2HI: begin
            l2_d = {data_i, 8'd0};
            phase_d = PH_L2LO;
          end
          PH_L2LO: begin
            l2_d = {l2_d[15:8], data_i};
            if (l2_d != '0) begin
              fc_d = l2_d;
              phase_d = PH_SKIP2;
            end else begin
              done = 1'b1;
            end
          end
          PH_SKIP2: begin
            fc_d = fc_d - 16'd1;
            done = (fc_d == '0);
          end
          PH_VINT: begin
            if (vcnt_d[2]) begin
              res_valid_o = 1'b1;
              res_o.status = ST_VINT_LONG;
              res_o.prop_id = id_d;
              res_o.value_kind = K_VARINT;
              res_o.section_end = 1'b1;
            end else begin
              vacc_d = vacc_d + vgroup(vcnt_d[1:0], data_i[6:0]);
              vcnt_d = vcnt_d + 3'd1;
              if (!data_i[7]) begin
                val_d = {4'd0, vacc_d};
                done = 1'b1;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
        if (done) begin
          numeric = (kind_d == K_BYTE) || (kind_d == K_TWO) || (kind_d == K_FOUR) ||
                    (kind_d == K_VARINT);
          phase_d = PH_ID;
          res_valid_o = 1'b1;
          res_o.status = ST_DONE;
          res_o.prop_id = id_d;
          res_o.value_kind = kind_d;
          res_o.num_value = numeric ? val_d : 32'd0;
          res_o.first_len = numeric ? 16'd0 : l1_d;
          res_o.second_len = (kind_d == K_PAIR) ? l2_d : 16'd0;
          res_o.content_offset = numeric ? '0 : cpos_d;
          res_o.section_end = (rem_d == '0);
        end else if (!res_valid_o && phase_d != PH_IDLE && rem_d == '0) begin
          res_valid_o = 1'b1;
          res_o.status = ST_OVERRUN;
          res_o.prop_id = id_d;
          res_o.value_kind = kind_d;
          res_o.section_end = 1'b1;
        end
      end
      if (res_valid_o && res_o.section_end) phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; rem_q <= '0; vacc_q <= '0; vcnt_q <= '0;
      id_q <= '0; kind_q <= '0; fc_q <= '0; val_q <= '0;
      l1_q <= '0; l2_q <= '0; bp_q <= '0; cpos_q <= '0;
    end else begin
      phase_q <= phase_d; rem_q <= rem_d; vacc_q <= vacc_d; vcnt_q <= vcnt_d;
      id_q <= id_d; kind_q <= kind_d; fc_q <= fc_d; val_q <= val_d;
      l1_q <= l1_d; l2_q <= l2_d; bp_q <= bp_d; cpos_q <= cpos_d;
    end
  end

endmodule

[src/mqtt5_property_list_parser_top.sv]
// MQTT 5 property list parser: top level with stream ports and result register.
// Takes one byte of a property section per cycle and returns one 136-bit
// descriptor per finished property, per empty section or per error. A descriptor
// lands in the output register at the edge that accepts the byte finishing it,
// so it is visible in the next cycle; the byte port stays ready while that
// register is empty or being drained, giving a sustained rate of one byte per
// cycle, limited only by the single output register under backpressure.
// tuser high marks the first byte of a section and restarts the parser.
module mqtt5_property_list_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] section_start
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [2:0] status, [10:3] prop_id, [13:11] value_kind, [45:14] num_value,
  // [61:46] first_len, [77:62] second_len, [106:78] content_offset,
  // [135:107] bytes_used
  output logic [135:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o    // section_end
);
  import mqttpp_pkg::*;

  logic beat;
  logic res_valid;
  res_t res;
  logic m_valid_q;
  res_t m_data_q;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign beat = s_axis_tvalid_i && s_axis_tready_o;

  mqttpp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_i      (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = m_data_q.section_end;
  assign m_axis_tdata_o  = {m_data_q.bytes_used, m_data_q.content_offset,
                            m_data_q.second_len, m_data_q.first_len,
                            m_data_q.num_value, m_data_q.value_kind,
                            m_data_q.prop_id, m_data_q.status};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!m_valid_q || m_axis_tready_i))
    else $error("result overwrites undelivered beat");

  a_error_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q.status != ST_DONE) |-> m_data_q.section_end)
    else $error("error result does not close section");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q.status != ST_DONE) |->
      (m_data_q.num_value == '0 && m_data_q.first_len == '0 &&
       m_data_q.second_len == '0 && m_data_q.content_offset == '0))
    else $error("error result carries value fields");

endmodule

[sim/parser_check_pkg.sv]
// Property id table, walk states and descriptor scoreboard for the property parser bench.
`timescale 1ns / 100ps
package parser_check_pkg;
  import mqttpp_pkg::*;

  localparam int NUM_IDS = 27;
  localparam logic [7:0] KNOWN_ID [NUM_IDS] = '{
    8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A,
    8'h13, 8'h21, 8'h22, 8'h23,
    8'h02, 8'h11, 8'h18, 8'h27,
    8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F,
    8'h09, 8'h16,
    8'h26,
    8'h0B};
  localparam logic [2:0] KNOWN_KIND [NUM_IDS] = '{
    K_BYTE, K_BYTE, K_BYTE, K_BYTE, K_BYTE, K_BYTE, K_BYTE, K_BYTE,
    K_TWO, K_TWO, K_TWO, K_TWO,
    K_FOUR, K_FOUR, K_FOUR, K_FOUR,
    K_STRING, K_STRING, K_STRING, K_STRING, K_STRING, K_STRING, K_STRING,
    K_BINARY, K_BINARY,
    K_PAIR,
    K_VARINT};

  typedef enum logic [3:0] {
    S_IDLE, S_SEC_LEN, S_PROP_ID, S_FIXED, S_LEN1_HI, S_LEN1_LO,
    S_SKIP1, S_LEN2_HI, S_LEN2_LO, S_SKIP2, S_VARINT
  } walk_e;

  class parse_scoreboard;
    walk_e           state;
    logic [27:0]     left_len;
    logic [27:0]     vi_acc;
    logic [2:0]      vi_cnt;
    logic [7:0]      id_q;
    logic [2:0]      kind_q;
    logic [15:0]     cnt;
    logic [31:0]     num_acc;
    logic [15:0]     len_a;
    logic [15:0]     len_b;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] cont_pos;
    logic [2:0]      id_kind [256];
    res_t            due_q [$];
    int unsigned     errors;
    int unsigned     n_seen;

    function new();
      foreach (id_kind[i]) id_kind[i] = K_NONE;
      for (int i = 0; i < NUM_IDS; i++) id_kind[KNOWN_ID[i]] = KNOWN_KIND[i];
      clear();
      errors = 0;
      n_seen = 0;
    endfunction

    function void clear();
      state    = S_IDLE;
      left_len = '0;
      vi_acc   = '0;
      vi_cnt   = '0;
      id_q     = '0;
      kind_q   = K_BYTE;
      cnt      = '0;
      num_acc  = '0;
      len_a    = '0;
      len_b    = '0;
      pos      = '0;
      cont_pos = '0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // 0: more bytes, 1: complete, 2: fifth byte
    function int vi_feed(logic [7:0] b);
      if (vi_cnt >= 3'd4) return 2;
      vi_acc = vi_acc + (28'(b[6:0]) << (7 * vi_cnt));
      vi_cnt = vi_cnt + 1'b1;
      return b[7] ? 0 : 1;
    endfunction

    function void queue_desc(logic [2:0] st, logic [7:0] id, logic [2:0] kind,
                             logic [31:0] num, logic [15:0] l1, logic [15:0] l2,
                             logic [PosW-1:0] coff, logic last);
      res_t d;
      d.status         = st;
      d.prop_id        = id;
      d.value_kind     = kind;
      d.num_value      = num;
      d.first_len      = l1;
      d.second_len     = l2;
      d.content_offset = coff;
      d.bytes_used     = pos;
      d.section_end    = last;
      due_q.push_back(d);
      if (last) state = S_IDLE;
    endfunction

    function void note_byte(logic [7:0] b, logic opens);
      logic fin;
      logic numeric;
      int   r;
      fin = 1'b0;
      if (opens) begin
        clear();
        state = S_SEC_LEN;
      end else if (state == S_IDLE) begin
        return;
      end
      pos = pos + 1'b1;

      if (state == S_SEC_LEN) begin
        r = vi_feed(b);
        if (r == 2) begin
          queue_desc(ST_VINT_LONG, 8'h00, K_BYTE, '0, '0, '0, '0, 1'b1);
        end else if (r == 1) begin
          left_len = vi_acc;
          if (left_len == '0) queue_desc(ST_EMPTY, 8'h00, K_BYTE, '0, '0, '0, '0, 1'b1);
          else state = S_PROP_ID;
        end
        return;
      end

      left_len = left_len - 1'b1;
      case (state)
        S_PROP_ID: begin
          id_q   = b;
          kind_q = id_kind[b];
          if (kind_q == K_NONE) begin
            kind_q = K_BYTE;
            queue_desc(ST_UNKNOWN, b, K_BYTE, '0, '0, '0, '0, 1'b1);
            return;
          end
          num_acc  = '0;
          len_a    = '0;
          len_b    = '0;
          cont_pos = '0;
          if (kind_q <= K_FOUR) begin
            cnt   = (kind_q == K_BYTE) ? 16'd1 : (kind_q == K_TWO) ? 16'd2 : 16'd4;
            state = S_FIXED;
          end else if (kind_q == K_VARINT) begin
            vi_acc = '0;
            vi_cnt = '0;
            state  = S_VARINT;
          end else begin
            state = S_LEN1_HI;
          end
        end
        S_FIXED: begin
          num_acc = {num_acc[23:0], b};
          cnt = cnt - 1'b1;
          if (cnt == '0) fin = 1'b1;
        end
        S_LEN1_HI: begin
          len_a = {b, 8'h00};
          state = S_LEN1_LO;
        end
        S_LEN1_LO: begin
          len_a[7:0] = b;
          cont_pos = pos;
          if (len_a != '0) begin
            cnt = len_a;
            state = S_SKIP1;
          end else if (kind_q == K_PAIR) begin
            state = S_LEN2_HI;
          end else begin
            fin = 1'b1;
          end
        end
        S_SKIP1: begin
          cnt = cnt - 1'b1;
          if (cnt == '0) begin
            if (kind_q == K_PAIR) state = S_LEN2_HI;
            else fin = 1'b1;
          end
        end
        S_LEN2_HI: begin
          len_b = {b, 8'h00};
          state = S_LEN2_LO;
        end
        S_LEN2_LO: begin
          len_b[7:0] = b;
          if (len_b != '0) begin
            cnt = len_b;
            state = S_SKIP2;
          end else begin
            fin = 1'b1;
          end
        end
        S_SKIP2: begin
          cnt = cnt - 1'b1;
          if (cnt == '0) fin = 1'b1;
        end
        S_VARINT: begin
          r = vi_feed(b);
          // too long wins over running out of section
          if (r == 2) begin
            queue_desc(ST_VINT_LONG, id_q, K_VARINT, '0, '0, '0, '0, 1'b1);
            return;
          end
          if (r == 1) begin
            num_acc = 32'(vi_acc);
            fin = 1'b1;
          end
        end
        default: begin
          state = S_IDLE;
          return;
        end
      endcase

      if (fin) begin
        numeric = (kind_q <= K_FOUR) || (kind_q == K_VARINT);
        state = S_PROP_ID;
        queue_desc(ST_DONE, id_q, kind_q, numeric ? num_acc : 32'd0,
                   numeric ? 16'd0 : len_a, (kind_q == K_PAIR) ? len_b : 16'd0,
                   numeric ? '0 : cont_pos, left_len == '0);
      end else if (left_len == '0) begin
        queue_desc(ST_OVERRUN, id_q, kind_q, '0, '0, '0, '0, 1'b1);
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task cmp(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("desc %0d %s got %0h want %0h", n_seen, field, got, want));
    endtask

    task check(res_t got);
      res_t want;
      if (due_q.size() == 0) begin
        report($sformatf("desc %0d not due: %h", n_seen, got));
        n_seen++;
        return;
      end
      want = due_q.pop_front();
      cmp("status", 32'(got.status), 32'(want.status));
      cmp("prop_id", 32'(got.prop_id), 32'(want.prop_id));
      cmp("value_kind", 32'(got.value_kind), 32'(want.value_kind));
      cmp("num_value", got.num_value, want.num_value);
      cmp("first_len", 32'(got.first_len), 32'(want.first_len));
      cmp("second_len", 32'(got.second_len), 32'(want.second_len));
      cmp("content_offset", 32'(got.content_offset), 32'(want.content_offset));
      cmp("bytes_used", 32'(got.bytes_used), 32'(want.bytes_used));
      cmp("section_end", 32'(got.section_end), 32'(want.section_end));
      n_seen++;
    endtask

    task flush();
      res_t left;
      while (due_q.size() != 0) begin
        left = due_q.pop_front();
        report($sformatf("desc never came: %h", left));
      end
    endtask
  endclass

endpackage

[sim/tb.sv]
// Bench top: streams MQTT 5 property sections into the parser and checks each descriptor.
`timescale 1ns / 100ps
module tb;
  import mqttpp_pkg::*;
  import parser_check_pkg::*;

  typedef struct packed {
    logic       st;
    logic [7:0] d;
  } beat_t;

  logic         clk_i;
  logic         rst_ni  = 1'b0;
  logic         s_valid = 1'b0;
  logic [7:0]   s_data  = 8'h00;
  logic         s_user  = 1'b0;
  logic         m_ready = 1'b0;
  logic         s_ready;
  logic         m_valid;
  logic [135:0] m_data;
  logic         m_last;

  parse_scoreboard sb;
  res_t            seen;
  beat_t           stim_q [$];
  logic [7:0]      sec_body [$];
  logic [7:0]      var_q [$];
  int unsigned     live_cnt;
  int unsigned     idle_pct  = 0;
  int unsigned     stall_pct = 0;
  int unsigned     idle_set [4] = '{0, 65, 0, 6};
  int unsigned     stall_set [4] = '{0, 0, 65, 6};

  mqtt5_property_list_parser_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      seen.status         = m_data[2:0];
      seen.prop_id        = m_data[10:3];
      seen.value_kind     = m_data[13:11];
      seen.num_value      = m_data[45:14];
      seen.first_len      = m_data[61:46];
      seen.second_len     = m_data[77:62];
      seen.content_offset = m_data[106:78];
      seen.bytes_used     = m_data[135:107];
      seen.section_end    = m_last;
      sb.check(seen);
    end
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void put(logic st, logic [7:0] d);
    stim_q.push_back({st, d});
    live_cnt++;
  endfunction

  // bytes the parser ignores while idle
  function automatic void put_idle(logic [7:0] d);
    stim_q.push_back({1'b0, d});
  endfunction

  function automatic void encode_varint(int unsigned v, int unsigned pad);
    int unsigned n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    n = (n + pad > 4) ? 4 : n + pad;
    var_q.delete();
    for (int i = 0; i < n; i++) var_q.push_back({i < n - 1, 7'(v >> (7 * i))});
  endfunction

  function automatic void add_string();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(199);
    n = (r < 20) ? 0 : (r < 198) ? $urandom_range(1, 6) : $urandom_range(256, 420);
    sec_body.push_back(8'(n >> 8));
    sec_body.push_back(8'(n));
    repeat (n) sec_body.push_back(8'($urandom));
  endfunction

  function automatic void gen_prop(logic [2:0] kind);
    int unsigned idx;
    int unsigned nb;
    int unsigned v;
    do idx = $urandom_range(NUM_IDS - 1); while (KNOWN_KIND[idx] != kind);
    sec_body.push_back(KNOWN_ID[idx]);
    case (kind)
      K_BYTE, K_TWO, K_FOUR: begin
        nb = (kind == K_BYTE) ? 1 : (kind == K_TWO) ? 2 : 4;
        v = $urandom_range(9);
        repeat (nb) sec_body.push_back(v == 0 ? 8'hFF : v == 1 ? 8'h00 : 8'($urandom));
      end
      K_STRING, K_BINARY: add_string();
      K_PAIR: begin
        add_string();
        add_string();
      end
      default: begin
        nb = $urandom_range(1, 4);
        v = $urandom & ((32'd1 << (7 * nb)) - 1);
        if ($urandom_range(7) == 0) v = (32'd1 << (7 * nb)) - 1;
        encode_varint(v, $urandom_range(0, 4 - nb));
        foreach (var_q[i]) sec_body.push_back(var_q[i]);
      end
    endcase
  endfunction

  function automatic void gen_section();
    int unsigned mode;
    int unsigned n_props;
    int unsigned len;
    int unsigned stop;
    int unsigned pad;
    logic [7:0]  u;
    sec_body.delete();
    mode = $urandom_range(99);
    if ($urandom_range(9) == 0) put_idle(8'($urandom));
    n_props = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 5);
    for (int i = 0; i < n_props; i++) gen_prop(3'($urandom_range(6)));
    len  = sec_body.size();
    stop = sec_body.size();
    if (mode < 8 && len > 1) begin
      len = $urandom_range(1, len - 1);
    end else if (mode < 14) begin
      len = len + $urandom_range(1, 3);
    end else if (mode < 19) begin
      do u = 8'($urandom); while (sb.id_kind[u] != K_NONE);
      sec_body.push_back(u);
      len = sec_body.size() + $urandom_range(0, 2);
      repeat ($urandom_range(0, 2)) sec_body.push_back(8'($urandom));
      stop = sec_body.size();
    end else if (mode < 23) begin
      sec_body.push_back(8'h0B);
      repeat (4) sec_body.push_back(8'($urandom_range(128, 255)));
      sec_body.push_back(8'($urandom));
      len = sec_body.size() + $urandom_range(0, 2);
      stop = sec_body.size();
    end else if (mode < 27) begin
      // length field runs to a fifth byte
      put(1'b1, 8'($urandom_range(128, 255)));
      repeat (3) put(1'b0, 8'($urandom_range(128, 255)));
      put(1'b0, 8'($urandom));
      foreach (sec_body[i]) put_idle(sec_body[i]);
      return;
    end else if (mode < 31) begin
      put(1'b1, 8'($urandom));
      repeat ($urandom_range(1, 12)) put($urandom_range(24) == 0, 8'($urandom));
      return;
    end else if (mode < 36 && stop > 0) begin
      // cut short, the next section start abandons it
      stop = $urandom_range(0, stop - 1);
    end
    pad = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    encode_varint(len, pad);
    foreach (var_q[i]) put(i == 0, var_q[i]);
    for (int i = 0; i < stop; i++) put(1'b0, sec_body[i]);
  endfunction

  task automatic send_pending();
    beat_t bt;
    while (stim_q.size() != 0) begin
      bt = stim_q.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
      s_valid <= 1'b1;
      s_data  <= bt.d;
      s_user  <= bt.st;
      do @(posedge clk_i); while (!s_ready);
      sb.note_byte(bt.d, bt.st);
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    put_idle(8'hAA);
    put(1'b1, 8'h00);
    put(1'b1, 8'hFF);
    repeat (3) put(1'b0, 8'hFF);
    put(1'b0, 8'h7F);
    // varint value too long on the last byte of the section
    put(1'b1, 8'h06);
    put(1'b0, 8'h0B);
    repeat (4) put(1'b0, 8'hFF);
    put(1'b0, 8'h80);
    put(1'b1, 8'h02);
    put(1'b0, 8'h00);
    put(1'b1, 8'h02);
    put(1'b0, 8'h02);
    put(1'b0, 8'h12);
    put(1'b1, 8'h05);
    put(1'b0, 8'h26);
    repeat (4) put(1'b0, 8'h00);
    put(1'b1, 8'h04);
    put(1'b0, 8'h01);
    put(1'b1, 8'h02);
    put(1'b0, 8'h2A);
    put(1'b0, 8'hFF);
    put(1'b1, 8'h85);
    put(1'b0, 8'h00);
    put(1'b0, 8'h27);
    repeat (4) put(1'b0, 8'hFF);
    send_pending();
    s_valid <= 1'b0;
    wait_quiet();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      live_cnt  = 0;
      while (live_cnt < 440) begin
        gen_section();
        send_pending();
      end
      s_valid <= 1'b0;
      if (p < 3) wait_quiet();
    end

    repeat (20000) begin
      if (sb.pending() == 0) break;
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    sb.flush();
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
